// ===== design/tmp_pkg.sv =====
// ============================================================================
// tmp_pkg
// Types and constants shared by the three-mode pulse/PWM timer modules.
// ============================================================================
`default_nettype none

package tmp_pkg;

  // Item kinds; code 3 carries no action and reports the state only
  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_TRIGGER = 2'd1,
    KIND_POLL    = 2'd2
  } kind_e;

  // Output modes
  typedef enum logic [1:0] {
    MODE_PULSE   = 2'd0,
    MODE_TOGGLE  = 2'd1,
    MODE_ONESHOT = 2'd2
  } mode_e;

  localparam int unsigned CntW = 9;
  localparam int unsigned AdcW = 8;

  // Toggle mode wraps the tick counter once it passes this value
  localparam logic [CntW-1:0] ToggleWrap = 9'd256;

  typedef struct packed {
    logic [1:0]      mode;
    logic            select_timer;
    logic            select_pulse;
    logic            level_high;
    logic [AdcW-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic       drive_level;
    logic       timer_on;
    logic [1:0] active_mode;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/tmp_in_if.sv =====
// ============================================================================
// tmp_in_if
// Input channel: valid/ready handshake with the trigger/tick/poll item.
// ============================================================================
`default_nettype none

interface tmp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       select_timer;
  logic       select_pulse;
  logic       level_high;
  logic [7:0] adc_sample;

  modport source (output valid, output mode, output select_timer, output select_pulse,
                  output level_high, output adc_sample, input ready);
  modport sink   (input valid, input mode, input select_timer, input select_pulse,
                  input level_high, input adc_sample, output ready);
endinterface

`default_nettype wire

// ===== design/tmp_out_if.sv =====
// ============================================================================
// tmp_out_if
// Result channel: valid/ready handshake with the output state item.
// ============================================================================
`default_nettype none

interface tmp_out_if;
  logic       valid;
  logic       ready;
  logic       drive_level;
  logic       timer_on;
  logic [1:0] active_mode;

  modport source (output valid, output drive_level, output timer_on,
                  output active_mode, input ready);
  modport sink   (input valid, input drive_level, input timer_on,
                  input active_mode, output ready);
endinterface

`default_nettype wire

// ===== design/tmp_in_stage.sv =====
// ============================================================================
// tmp_in_stage
// Input register: capture one item per cycle while the core keeps taking them, and hand it to the core.
// ============================================================================
`default_nettype none

module tmp_in_stage
  import tmp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          item_valid_o,
  input  wire logic     item_ready_i,
  output in_item_t      item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign in_ready_o   = !valid_q || item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/tmp_core.sv =====
// ============================================================================
// tmp_core
// Timer state, single-pass next-state logic and the result register.
// ============================================================================
`default_nettype none

module tmp_core
  import tmp_pkg::*;
#(
  parameter int unsigned PERIOD_TICKS = 17
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     item_valid_i,
  output logic          item_ready_o,
  input  wire in_item_t item_i,
  output logic          res_valid_o,
  input  wire logic     res_ready_i,
  output out_item_t     res_o
);

  localparam logic [CntW-1:0] PeriodLimit = CntW'(PERIOD_TICKS);

  mode_e           mode_q, mode_d;
  logic [AdcW-1:0] limit_q, limit_d;
  logic [CntW-1:0] tick_q, tick_d;
  logic [CntW-1:0] per_q, per_d;
  logic            flag_q, flag_d;
  logic            level_q, level_d;
  logic            run_q, run_d;
  logic            res_valid_q;
  out_item_t       res_q;

  logic            step;
  logic [CntW-1:0] tick_inc;
  logic [CntW-1:0] per_inc;
  logic [CntW-1:0] limit_ext;

  assign item_ready_o = !res_valid_q || res_ready_i;
  assign step         = item_valid_i && item_ready_o;
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

  assign tick_inc  = tick_q + CntW'(1);
  assign per_inc   = per_q + CntW'(1);
  assign limit_ext = CntW'(limit_q);

  always_comb begin
    mode_d  = mode_q;
    limit_d = limit_q;
    tick_d  = tick_q;
    per_d   = per_q;
    flag_d  = flag_q;
    level_d = level_q;
    run_d   = run_q;
    case (kind_e'(item_i.mode))
      KIND_TICK: begin
        if (run_q) begin
          tick_d = tick_inc;
          case (mode_q)
            MODE_TOGGLE: begin
              level_d = tick_inc < limit_ext;
              if (tick_inc > ToggleWrap) begin
                tick_d = '0;
              end
            end
            MODE_ONESHOT: begin
              if (tick_inc > PeriodLimit) begin
                tick_d = '0;
                per_d  = per_inc;
                if (per_inc > limit_ext) begin
                  level_d = 1'b0;
                  run_d   = 1'b0;
                  per_d   = '0;
                end
              end
            end
            default: begin
              if (tick_inc > limit_ext) begin
                level_d = !level_q;
                tick_d  = '0;
              end
            end
          endcase
        end
      end
      KIND_TRIGGER: begin
        if (item_i.select_timer) begin
          mode_d  = MODE_ONESHOT;
          limit_d = {1'b0, item_i.adc_sample[AdcW-1:1]};
          tick_d  = '0;
          per_d   = '0;
          level_d = 1'b1;
          run_d   = 1'b1;
        end else if (item_i.select_pulse) begin
          mode_d  = MODE_PULSE;
          level_d = 1'b1;
        end else begin
          mode_d = MODE_TOGGLE;
          flag_d = !flag_q;
          tick_d = '0;
        end
      end
      KIND_POLL: begin
        if (item_i.select_pulse && item_i.level_high) begin
          limit_d = {2'b00, item_i.adc_sample[AdcW-1:2]};
          run_d   = 1'b1;
        end else if (!item_i.select_pulse && !item_i.select_timer) begin
          if (flag_q) begin
            limit_d = item_i.adc_sample;
            run_d   = 1'b1;
          end else begin
            run_d   = 1'b0;
            level_d = 1'b0;
          end
        end else if (item_i.select_pulse) begin
          run_d   = 1'b0;
          tick_d  = '0;
          level_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_PULSE;
      limit_q     <= '0;
      tick_q      <= '0;
      per_q       <= '0;
      flag_q      <= 1'b0;
      level_q     <= 1'b0;
      run_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (step) begin
        mode_q  <= mode_d;
        limit_q <= limit_d;
        tick_q  <= tick_d;
        per_q   <= per_d;
        flag_q  <= flag_d;
        level_q <= level_d;
        run_q   <= run_d;
      end
      if (item_ready_o) begin
        res_valid_q <= item_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q.drive_level <= level_d;
      res_q.timer_on    <= run_d;
      res_q.active_mode <= mode_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/three_mode_pulse_pwm_timer_top.sv =====
// ============================================================================
// three_mode_pulse_pwm_timer_top
// Pulse / software-PWM / timed one-shot output driver with item handshakes.
// ============================================================================
// Usage:
//   in_i carries one item per handshake: a timer tick, a trigger event or a
//   poll pass, with the switch levels and an ADC sample. out_o returns one
//   result item per input item: output level, timer running flag and the
//   active mode, all taken after that item's update.
//   An accepted item sits in the input register while the next-state logic
//   works on it, and the result register then captures the update.
//   Throughput is one item per cycle while out_o.ready stays high, set by
//   the state update in the core.
//   Reset clears all timer state (pulse mode, output low, timer stopped) and
//   empties both registers.
//   When the receiver stalls, the result register holds its item, the input
//   register holds the next one, and in_i.ready drops once both are full;
//   nothing is dropped or repeated.
//   PERIOD_TICKS sets the one-shot period: a period lasts PERIOD_TICKS+1
//   ticks (range 0..510).
// ============================================================================
`default_nettype none

module three_mode_pulse_pwm_timer_top
  import tmp_pkg::*;
#(
  parameter int unsigned PERIOD_TICKS = 17
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tmp_in_if.sink    in_i,
  tmp_out_if.source out_o
);

  in_item_t  in_item;
  in_item_t  stage_item;
  logic      stage_valid;
  logic      core_ready;
  out_item_t res;

  // Pack the input channel fields into one item
  assign in_item.mode         = in_i.mode;
  assign in_item.select_timer = in_i.select_timer;
  assign in_item.select_pulse = in_i.select_pulse;
  assign in_item.level_high   = in_i.level_high;
  assign in_item.adc_sample   = in_i.adc_sample;

  // Hold the accepted item until the core takes it
  tmp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_item_i    (in_item),
    .item_valid_o (stage_valid),
    .item_ready_i (core_ready),
    .item_o       (stage_item)
  );

  // Apply the item to the timer state and register the result
  tmp_core #(
    .PERIOD_TICKS (PERIOD_TICKS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (stage_valid),
    .item_ready_o (core_ready),
    .item_i       (stage_item),
    .res_valid_o  (out_o.valid),
    .res_ready_i  (out_o.ready),
    .res_o        (res)
  );

  // Unpack the result onto the output channel
  assign out_o.drive_level = res.drive_level;
  assign out_o.timer_on    = res.timer_on;
  assign out_o.active_mode = res.active_mode;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ============================================================================
// tb
// Self-checking bench for the three-mode pulse/PWM/one-shot timer: a short
// table of directed items, then scenario bursts per mode with random
// content, scored against typed results or an in-bench model of the timer state.
// ============================================================================

module tb
  import tmp_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PeriodTicks = 17;
  localparam int          NumItems    = 1650;
  localparam int          NumDir      = 20;
  localparam int          DrainCycles = 10;
  localparam int          ShowMax     = 10;

  // Item kind code with no action; the block only reports its state
  localparam logic [1:0] KindIdle = 2'd3;

  typedef struct packed {
    in_item_t  stim;
    logic      known;
    out_item_t want;
  } step_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tmp_in_if  in_if ();
  tmp_out_if out_if ();

  three_mode_pulse_pwm_timer_top #(
    .PERIOD_TICKS(PeriodTicks)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Timer model: mirror of the block's state, advanced once per accepted item
  // --------------------------------------------------------------------------
  mode_e          m_mode;
  logic [7:0]     m_limit;
  logic [CntW-1:0] m_ticks;
  logic [CntW-1:0] m_periods;
  logic           m_toggle;
  logic           m_level;
  logic           m_run;

  out_item_t pending_status_q [$];

  int n_sent;
  int n_checked;
  int n_errors;
  int n_expiries;
  int n_wraps;
  int kind_cnt [4];

  // Idle pressure per burst, in percent, for the sender and the receiver
  int src_pct;
  int snk_pct;
  int stall_left;

  function automatic out_item_t timer_step(input in_item_t it);
    out_item_t res;
    case (it.mode)
      KIND_TICK: begin
        // A stopped timer ignores ticks
        if (m_run) begin
          m_ticks = m_ticks + 1'b1;
          case (m_mode)
            MODE_TOGGLE: begin
              m_level = (m_ticks < {1'b0, m_limit});
              if (m_ticks > ToggleWrap) begin
                m_ticks = '0;
                n_wraps++;
              end
            end
            MODE_ONESHOT: begin
              if (m_ticks > PeriodTicks) begin
                m_periods = m_periods + 1'b1;
                if (m_periods > {1'b0, m_limit}) begin
                  m_level   = 1'b0;
                  m_run     = 1'b0;
                  m_periods = '0;
                  n_expiries++;
                end
                m_ticks = '0;
              end
            end
            default: begin
              if (m_ticks > {1'b0, m_limit}) begin
                m_level = ~m_level;
                m_ticks = '0;
              end
            end
          endcase
        end
      end
      KIND_TRIGGER: begin
        if (it.select_timer) begin
          m_mode    = MODE_ONESHOT;
          m_limit   = {1'b0, it.adc_sample[7:1]};
          m_ticks   = '0;
          m_periods = '0;
          m_level   = 1'b1;
          m_run     = 1'b1;
        end else if (it.select_pulse) begin
          m_mode  = MODE_PULSE;
          m_level = 1'b1;
        end else begin
          m_mode   = MODE_TOGGLE;
          m_toggle = ~m_toggle;
          m_ticks  = '0;
        end
      end
      KIND_POLL: begin
        if (it.select_pulse && it.level_high) begin
          m_limit = {2'b00, it.adc_sample[7:2]};
          m_run   = 1'b1;
        end else if (!it.select_pulse && !it.select_timer) begin
          if (m_toggle) begin
            m_limit = it.adc_sample;
            m_run   = 1'b1;
          end else begin
            m_run   = 1'b0;
            m_level = 1'b0;
          end
        end else if (it.select_pulse) begin
          m_run   = 1'b0;
          m_ticks = '0;
          m_level = 1'b0;
        end
      end
      default: ;  // idle code: state untouched
    endcase
    res.drive_level = m_level;
    res.timer_on    = m_run;
    res.active_mode = m_mode;
    return res;
  endfunction

  function automatic in_item_t mk_item(input logic [1:0] kind, input logic t,
                                       input logic p, input logic l,
                                       input logic [7:0] adc);
    in_item_t it;
    it.mode         = kind;
    it.select_timer = t;
    it.select_pulse = p;
    it.level_high   = l;
    it.adc_sample   = adc;
    return it;
  endfunction

  function automatic in_item_t any_item();
    return mk_item(2'($urandom_range(3)), 1'($urandom), 1'($urandom), 1'($urandom),
                   8'($urandom_range(255)));
  endfunction

  // Mostly short gaps, a few long ones; zero unless the pressure hits
  function automatic int gap_len(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 15;
      default: return 50;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender: hold the item until accepted, then record what it should produce.
  // Valid stays high across back-to-back items, so it gets one update per step.
  // --------------------------------------------------------------------------
  task automatic send_item(input in_item_t it, input logic known, input out_item_t want);
    int        gap;
    out_item_t pred;
    gap = gap_len(src_pct);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.mode         <= it.mode;
    in_if.select_timer <= it.select_timer;
    in_if.select_pulse <= it.select_pulse;
    in_if.level_high   <= it.level_high;
    in_if.adc_sample   <= it.adc_sample;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    // Accepted at this edge: advance the model regardless of a typed result
    pred = timer_step(it);
    pending_status_q.push_back(known ? want : pred);
    n_sent++;
    kind_cnt[it.mode]++;
  endtask

  task automatic send_pred(input in_item_t it);
    send_item(it, 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, bursts of them long now and then
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      int len;
      len = gap_len(snk_pct);
      out_if.ready <= (len == 0);
      stall_left   <= (len > 0) ? len - 1 : 0;
    end
  end

  function automatic void flag_mismatch(input string what, input int want, input int got);
    n_errors++;
    if (n_errors <= ShowMax)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  // Score each result against the oldest pending expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      out_item_t want;
      if (pending_status_q.size() == 0) begin
        flag_mismatch("unexpected result (queue empty), drive_level", 0,
                      int'(out_if.drive_level));
      end else begin
        want = pending_status_q.pop_front();
        n_checked++;
        if (out_if.drive_level !== want.drive_level)
          flag_mismatch("drive_level", int'(want.drive_level), int'(out_if.drive_level));
        if (out_if.timer_on !== want.timer_on)
          flag_mismatch("timer_on", int'(want.timer_on), int'(out_if.timer_on));
        if (out_if.active_mode !== want.active_mode)
          flag_mismatch("active_mode", int'(want.active_mode), int'(out_if.active_mode));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  step_row_t dir_tab [NumDir];

  initial begin
    int       burst;
    int       n_ticks;
    logic [7:0] adc;

    // Known levels on every input from time zero
    in_if.valid        = 1'b0;
    in_if.mode         = KIND_TICK;
    in_if.select_timer = 1'b0;
    in_if.select_pulse = 1'b0;
    in_if.level_high   = 1'b0;
    in_if.adc_sample   = '0;
    out_if.ready       = 1'b0;
    stall_left         = 0;
    src_pct            = 0;
    snk_pct            = 0;

    // Model starts from the reset state
    m_mode    = MODE_PULSE;
    m_limit   = '0;
    m_ticks   = '0;
    m_periods = '0;
    m_toggle  = 1'b0;
    m_level   = 1'b0;
    m_run     = 1'b0;

    // Directed walk: known rows carry their result; the rest use the model.
    // Fields: kind, timer switch, pulse switch, level, adc.
    dir_tab = '{
      // tick after reset: stopped, nothing moves
      '{mk_item(KIND_TICK,    1'b0, 1'b0, 1'b0, 8'h00), 1'b1, '{1'b0, 1'b0, MODE_PULSE}},
      // idle code with every bit set: state only
      '{mk_item(KindIdle,     1'b1, 1'b1, 1'b1, 8'hFF), 1'b1, '{1'b0, 1'b0, MODE_PULSE}},
      // pulse enable high: limit from top adc, timer starts
      '{mk_item(KIND_POLL,    1'b0, 1'b1, 1'b1, 8'hFF), 1'b1, '{1'b0, 1'b1, MODE_PULSE}},
      '{mk_item(KIND_TICK,    1'b0, 1'b0, 1'b0, 8'h00), 1'b0, '0},
      // smallest pulse limit
      '{mk_item(KIND_POLL,    1'b0, 1'b1, 1'b1, 8'h00), 1'b1, '{1'b0, 1'b1, MODE_PULSE}},
      '{mk_item(KIND_TICK,    1'b0, 1'b0, 1'b0, 8'h00), 1'b0, '0},
      // one-shot with the largest limit; timer switch wins over pulse
      '{mk_item(KIND_TRIGGER, 1'b1, 1'b1, 1'b0, 8'hFF), 1'b1, '{1'b1, 1'b1, MODE_ONESHOT}},
      '{mk_item(KIND_TICK,    1'b0, 1'b0, 1'b0, 8'h00), 1'b0, '0},
      '{mk_item(KIND_TRIGGER, 1'b0, 1'b1, 1'b0, 8'h55), 1'b1, '{1'b1, 1'b1, MODE_PULSE}},
      // no switch: PWM mode, flag set
      '{mk_item(KIND_TRIGGER, 1'b0, 1'b0, 1'b0, 8'hAA), 1'b1, '{1'b1, 1'b1, MODE_TOGGLE}},
      '{mk_item(KIND_POLL,    1'b0, 1'b0, 1'b1, 8'hFF), 1'b1, '{1'b1, 1'b1, MODE_TOGGLE}},
      '{mk_item(KIND_TICK,    1'b0, 1'b0, 1'b0, 8'h00), 1'b0, '0},
      // flag cleared again
      '{mk_item(KIND_TRIGGER, 1'b0, 1'b0, 1'b1, 8'h00), 1'b1, '{1'b1, 1'b1, MODE_TOGGLE}},
      // flag clear: poll stops the timer and drops the output
      '{mk_item(KIND_POLL,    1'b0, 1'b0, 1'b0, 8'hFF), 1'b1, '{1'b0, 1'b0, MODE_TOGGLE}},
      // timer switch alone: poll does nothing
      '{mk_item(KIND_POLL,    1'b1, 1'b0, 1'b1, 8'hFF), 1'b1, '{1'b0, 1'b0, MODE_TOGGLE}},
      // pulse switch with level low: stop
      '{mk_item(KIND_POLL,    1'b1, 1'b1, 1'b0, 8'h00), 1'b1, '{1'b0, 1'b0, MODE_TOGGLE}},
      // one-shot with the smallest limit
      '{mk_item(KIND_TRIGGER, 1'b1, 1'b0, 1'b0, 8'h00), 1'b1, '{1'b1, 1'b1, MODE_ONESHOT}},
      '{mk_item(KindIdle,     1'b0, 1'b0, 1'b0, 8'h00), 1'b1, '{1'b1, 1'b1, MODE_ONESHOT}},
      '{mk_item(KIND_TICK,    1'b0, 1'b0, 1'b0, 8'h00), 1'b0, '0},
      '{mk_item(KIND_POLL,    1'b0, 1'b1, 1'b0, 8'h80), 1'b1, '{1'b0, 1'b0, MODE_ONESHOT}}
    };

    // Hold reset, then release it on an edge
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      src_pct = (i < 8) ? 0 : 30;
      snk_pct = (i < 8) ? 0 : 30;
      send_item(dir_tab[i].stim, dir_tab[i].known, dir_tab[i].want);
    end

    // Random bursts, one mode at a time: mostly well-formed sequences with
    // random content, salted with stray items; some bursts are pure noise.
    while (n_sent < NumItems) begin
      src_pct = pick_pct();
      snk_pct = pick_pct();
      burst   = $urandom_range(3);
      case (burst)
        0: begin
          // Pulse: select, load a limit, run, sometimes stop and tick idle
          send_pred(mk_item(KIND_TRIGGER, 1'b0, 1'b1, 1'($urandom), 8'($urandom_range(255))));
          send_pred(mk_item(KIND_POLL, 1'b0, 1'b1, 1'b1, 8'($urandom_range(255))));
          n_ticks = $urandom_range(10, 100);
          repeat (n_ticks) begin
            if ($urandom_range(39) == 0) send_pred(any_item());
            else send_pred(mk_item(KIND_TICK, 1'($urandom), 1'($urandom), 1'($urandom),
                                   8'($urandom_range(255))));
          end
          if ($urandom_range(1) == 0) begin
            send_pred(mk_item(KIND_POLL, 1'($urandom), 1'b1, 1'b0, 8'($urandom_range(255))));
            repeat ($urandom_range(1, 5)) send_pred(mk_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 8'h00));
          end
        end
        1: begin
          // PWM: flip the flag, poll to start or stop, then tick; now and then long enough to wrap
          send_pred(mk_item(KIND_TRIGGER, 1'b0, 1'b0, 1'($urandom), 8'($urandom_range(255))));
          send_pred(mk_item(KIND_POLL, 1'b0, 1'b0, 1'($urandom), 8'($urandom_range(255))));
          n_ticks = ($urandom_range(9) == 0) ? $urandom_range(257, 300) : $urandom_range(5, 60);
          repeat (n_ticks) begin
            if ($urandom_range(59) == 0) send_pred(any_item());
            else send_pred(mk_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 8'($urandom_range(255))));
          end
        end
        2: begin
          // One-shot: small limits mostly, so most shots run out
          adc = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
          send_pred(mk_item(KIND_TRIGGER, 1'b1, 1'($urandom), 1'($urandom), adc));
          n_ticks = (PeriodTicks + 1) * ((adc >> 1) + 1) + $urandom_range(4);
          if (n_ticks > 400) n_ticks = 400;
          repeat (n_ticks) begin
            if ($urandom_range(79) == 0) send_pred(any_item());
            else send_pred(mk_item(KIND_TICK, 1'($urandom), 1'($urandom), 1'($urandom),
                                   8'($urandom_range(255))));
          end
        end
        default: begin
          repeat ($urandom_range(5, 20)) send_pred(any_item());
        end
      endcase
    end

    in_if.valid <= 1'b0;
    snk_pct = 20;

    // Drain, then give stray results time to show up
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d items: %0d ticks, %0d triggers, %0d polls, %0d idle codes.",
             n_sent, kind_cnt[KIND_TICK], kind_cnt[KIND_TRIGGER], kind_cnt[KIND_POLL],
             kind_cnt[KindIdle]);
    $display("Checked %0d results; %0d one-shot expiries, %0d PWM counter wraps, %0d errors.",
             n_checked, n_expiries, n_wraps, n_errors);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still pending.", pending_status_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
